// File: rtl/vrfst_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the video register block.
// Used by vrfst_ctrl, vrfst_dp and video_register_file_scroll_timing.
package vrfst_pkg;

  localparam int NT_BYTES  = 2048;
  localparam int PAT_BYTES = 8192;
  localparam int SPR_BYTES = 256;
  localparam int NT_AW     = $clog2(NT_BYTES);
  localparam int PAT_AW    = $clog2(PAT_BYTES);
  localparam int SPR_AW    = $clog2(SPR_BYTES);

  localparam logic [10:0] DOTS_PER_LINE = 11'd341;
  localparam logic [8:0]  LINE_VBLANK   = 9'd241;
  localparam logic [8:0]  LINE_PRE      = 9'd261;
  localparam logic [8:0]  LINE_VISIBLE  = 9'd240;
  localparam logic [13:0] PAL_BASE      = 14'h3F00;
  localparam logic [13:0] NT_BASE       = 14'h2000;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_ELAPSE = 2'd2;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMA   = 3'd3;
  localparam logic [2:0] REG_OAMD   = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic CFG_MIRROR   = 1'b0;
  localparam logic CFG_PAT_WR   = 1'b1;

  localparam logic [1:0] MIR_LOWER = 2'd0;
  localparam logic [1:0] MIR_UPPER = 2'd1;
  localparam logic [1:0] MIR_VERT  = 2'd2;
  localparam logic [1:0] MIR_HORZ  = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] register_index;
    logic [7:0] write_data;
    logic [7:0] cpu_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic        frame_done;
    logic [1:0]  mapper_clocks;
    logic [14:0] vram_address;
    logic [2:0]  fine_scroll;
    logic [8:0]  line_number;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic exec;
    logic rd_done;
    logic line;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       line_due;
    logic       out_busy;
    logic [1:0] operation;
  } dp_status_t;

  function automatic logic [NT_AW-1:0] nt_index(input logic [1:0] mode,
                                                input logic [13:0] a);
    logic page;
    case (mode)
      MIR_UPPER: page = 1'b1;
      MIR_VERT:  page = a[10];
      MIR_HORZ:  page = a[11];
      default:   page = 1'b0;
    endcase
    return NT_AW'({page, a[9:0]});
  endfunction

  function automatic logic [4:0] pal_index(input logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
    return i;
  endfunction

  function automatic logic [14:0] next_row(input logic [14:0] v);
    logic [14:0] r;
    logic [4:0]  y;
    r = v;
    if (v[14:12] != 3'b111) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      y = v[9:5];
      r[14:12] = 3'b000;
      if (y == 5'd29) begin
        y = 5'd0;
        r[11] = ~r[11];
      end else if (y == 5'd31) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      r[9:5] = y;
    end
    return r;
  endfunction

endpackage

// File: rtl/vrfst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the video register block: clearing pass, per-item steps, result handoff.
// Depends on vrfst_pkg.
module vrfst_ctrl import vrfst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_READ, S_LINE, S_FINISH
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.clear   = (state == S_CLEAR);
    cmd.exec    = (state == S_EXEC);
    cmd.rd_done = (state == S_READ);
    cmd.line    = (state == S_LINE) && status.line_due;
    cmd.finish  = (state == S_FINISH) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (status.clear_last) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          case (status.operation)
            OP_READ:   state <= S_READ;
            OP_ELAPSE: state <= S_LINE;
            default:   state <= S_FINISH;
          endcase
        end
        S_READ:   state <= S_FINISH;
        S_LINE:   if (!status.line_due) state <= S_FINISH;
        S_FINISH: if (!status.out_busy) state <= S_IDLE;
        default:  state <= S_CLEAR;
      endcase
    end
  end

endmodule

// File: rtl/vrfst_dp.sv
`timescale 1ns / 1ps
// Datapath of the video register block: registers, scroll logic, memories, result register.
// Depends on vrfst_pkg; driven by vrfst_ctrl.
module vrfst_dp import vrfst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  in_item_t    in_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [1:0]  mirror_mode;
  logic        pattern_writable;
  in_item_t    item;
  logic [7:0]  control_reg, mask_reg, sprite_addr, read_buffer, rd;
  logic        vblank_flag, write_toggle, nmi, frame;
  logic [14:0] current_addr, temp_addr;
  logic [2:0]  fine_x;
  logic [8:0]  scanline_count;
  logic [10:0] dots;
  logic [1:0]  clocks;
  logic [NT_AW-1:0] clr_cnt;
  logic [5:0]  palette_ram [32];

  logic [7:0] nt_ram  [NT_BYTES];
  logic [7:0] spr_ram [SPR_BYTES];
  logic [7:0] pat_ram [PAT_BYTES];
  logic [7:0] nt_q, spr_q, pat_q;

  logic [13:0] a;
  logic        is_data_wr, nt_we, spr_we, pat_we, pal_we, render;
  logic [NT_AW-1:0]  nt_wa;
  logic [7:0]        nt_wd, spr_wd;
  logic [SPR_AW-1:0] spr_wa;
  logic [14:0] v_step;
  logic [8:0]  sl_next;

  assign a          = current_addr[13:0];
  assign render     = mask_reg[3] | mask_reg[4];
  assign v_step     = current_addr + (control_reg[2] ? 15'd32 : 15'd1);
  assign sl_next    = (scanline_count == LINE_PRE) ? 9'd0 : scanline_count + 9'd1;
  assign is_data_wr = cmd.exec && item.operation == OP_WRITE && item.register_index == REG_DATA;

  always_comb begin
    nt_we  = cmd.clear || (is_data_wr && a >= NT_BASE && a < PAL_BASE);
    nt_wa  = cmd.clear ? clr_cnt : nt_index(mirror_mode, a);
    nt_wd  = cmd.clear ? 8'd0 : item.write_data;
    spr_we = (cmd.clear && clr_cnt < NT_AW'(SPR_BYTES))
          || (cmd.exec && item.operation == OP_WRITE && item.register_index == REG_OAMD);
    spr_wa = cmd.clear ? clr_cnt[SPR_AW-1:0] : sprite_addr;
    spr_wd = cmd.clear ? 8'd0 : item.write_data;
    pat_we = is_data_wr && a < NT_BASE && pattern_writable;
    pal_we = is_data_wr && a >= PAL_BASE;
  end

  always_ff @(posedge clk) begin
    if (nt_we) nt_ram[nt_wa] <= nt_wd;
    nt_q <= nt_ram[nt_index(mirror_mode, a)];
  end

  always_ff @(posedge clk) begin
    if (spr_we) spr_ram[spr_wa] <= spr_wd;
    spr_q <= spr_ram[sprite_addr];
  end

  always_ff @(posedge clk) begin
    if (pat_we) pat_ram[a[PAT_AW-1:0]] <= item.write_data;
    pat_q <= pat_ram[a[PAT_AW-1:0]];
  end

  assign status.clear_last = (clr_cnt == NT_AW'(NT_BYTES - 1));
  assign status.line_due   = (dots >= DOTS_PER_LINE);
  assign status.out_busy   = out_valid && out_stall;
  assign status.operation  = item.operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode <= MIR_LOWER;
      pattern_writable <= 1'b0;
      control_reg <= '0;
      mask_reg <= '0;
      vblank_flag <= 1'b0;
      sprite_addr <= '0;
      current_addr <= '0;
      temp_addr <= '0;
      fine_x <= '0;
      write_toggle <= 1'b0;
      read_buffer <= '0;
      scanline_count <= '0;
      dots <= '0;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 32; i++) palette_ram[i] <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_MIRROR) mirror_mode <= cfg_data;
        else pattern_writable <= cfg_data[0];
      end
      if (cmd.clear) clr_cnt <= clr_cnt + NT_AW'(1);
      if (cmd.capture) item <= in_data;
      if (pal_we) palette_ram[pal_index(a)] <= item.write_data[5:0];

      if (cmd.exec) begin
        rd <= '0;
        nmi <= 1'b0;
        frame <= 1'b0;
        clocks <= '0;
        if (item.operation == OP_ELAPSE) begin
          dots <= dots + {2'b0, item.cpu_cycles, 1'b0} + {3'b0, item.cpu_cycles};
        end else if (item.operation == OP_WRITE) begin
          case (item.register_index)
            REG_CTRL: begin
              temp_addr[11:10] <= item.write_data[1:0];
              if (item.write_data[7] && !control_reg[7] && vblank_flag) nmi <= 1'b1;
              control_reg <= item.write_data;
            end
            REG_MASK: mask_reg <= item.write_data;
            REG_OAMA: sprite_addr <= item.write_data;
            REG_OAMD: sprite_addr <= sprite_addr + 8'd1;
            REG_SCROLL: begin
              if (!write_toggle) begin
                temp_addr[4:0] <= item.write_data[7:3];
                fine_x <= item.write_data[2:0];
              end else begin
                temp_addr[14:12] <= item.write_data[2:0];
                temp_addr[9:5] <= item.write_data[7:3];
              end
              write_toggle <= ~write_toggle;
            end
            REG_ADDR: begin
              if (!write_toggle) begin
                temp_addr[14:8] <= {1'b0, item.write_data[5:0]};
              end else begin
                temp_addr[7:0] <= item.write_data;
                current_addr <= {temp_addr[14:8], item.write_data};
              end
              write_toggle <= ~write_toggle;
            end
            REG_DATA: current_addr <= v_step;
            default: ;
          endcase
        end
      end

      if (cmd.rd_done) begin
        case (item.register_index)
          REG_STATUS: begin
            rd <= {vblank_flag, 7'd0};
            vblank_flag <= 1'b0;
            write_toggle <= 1'b0;
          end
          REG_OAMD: rd <= spr_q;
          REG_DATA: begin
            if (a >= PAL_BASE) begin
              rd <= {2'b0, palette_ram[pal_index(a)]};
              read_buffer <= nt_q;
            end else begin
              rd <= read_buffer;
              read_buffer <= (a < NT_BASE) ? pat_q : nt_q;
            end
            current_addr <= v_step;
          end
          default: ;
        endcase
      end

      if (cmd.line) begin
        dots <= dots - DOTS_PER_LINE;
        if (scanline_count < LINE_VISIBLE) begin
          if (render) begin
            if (clocks != 2'd3) clocks <= clocks + 2'd1;
            current_addr <= (next_row(current_addr) & ~15'h041F) | (temp_addr & 15'h041F);
          end
        end else if (scanline_count == LINE_PRE) begin
          if (render) current_addr <= temp_addr;
        end
        scanline_count <= sl_next;
        if (scanline_count == LINE_PRE) frame <= 1'b1;
        if (sl_next == LINE_VBLANK) begin
          vblank_flag <= 1'b1;
          if (control_reg[7]) nmi <= 1'b1;
        end else if (sl_next == LINE_PRE) begin
          vblank_flag <= 1'b0;
        end
      end

      if (cmd.finish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.read_data     <= rd;
      out_data.nmi_request   <= nmi;
      out_data.frame_done    <= frame;
      out_data.mapper_clocks <= clocks;
      out_data.vram_address  <= current_addr;
      out_data.fine_scroll   <= fine_x;
      out_data.line_number   <= scanline_count;
    end
  end

endmodule

// File: rtl/video_register_file_scroll_timing.sv
`timescale 1ns / 1ps
// Top level of the video register block: register file, scroll registers, line timing.
// Depends on vrfst_pkg, vrfst_ctrl and vrfst_dp.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one bus operation per transfer:
//   a register write, a register read, or an elapse item carrying elapsed CPU time.
//   Output channel out_valid/out_stall/out_data returns exactly one result per item.
//   Configuration writes (mirroring mode, pattern store writable) go through
//   cfg_write/cfg_index/cfg_data while no item is in flight.
// Timing:
//   Register writes go from transfer through the execute and finish states to their
//   result; reads add a read state (one registered memory read), and elapse items
//   add the line loop, which ends n (0..3) scanlines and steps one scanline per cycle.
//   A new item is taken in the cycle after the previous result is loaded into the
//   output register, so a waiting result does not block the next transfer.
// Reset:
//   After rst, a clearing pass zeroes nametable and sprite memory;
//   in_stall stays high during it. Palette entries and registers clear at once.
// Stall:
//   A stalled result holds in the output register; the next item runs up to
//   its result and then waits.
module video_register_file_scroll_timing import vrfst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  vrfst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vrfst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for video_register_file_scroll_timing: directed and random bus operations
// checked against an in-bench register, memory and line timing predictor.
// Depends on vrfst_pkg and the RTL of the block.
module tb;
  import vrfst_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [1:0] cfg_data = 2'd0;

  video_register_file_scroll_timing i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [1:0]  mirror;
  logic        pat_wr;
  logic [7:0]  ctrl_q, mask_q, oam_addr, rd_buf;
  logic        vblank, toggle;
  logic [14:0] v_addr, t_addr;
  logic [2:0]  fine_q;
  int          line_q, dot_q;
  logic [7:0]  nt_mem [NT_BYTES];
  logic [5:0]  pal_mem [32];
  logic [7:0]  spr_mem [SPR_BYTES];
  logic [7:0]  pat_mem [PAT_BYTES];
  bit          pat_known [PAT_BYTES];

  out_item_t result_q[$];
  int        fails = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  int        hold_req = 0, hold_ack = 0, hold_left = 0;

  function automatic logic [10:0] nt_slot(input logic [13:0] a);
    logic page;
    case (mirror)
      MIR_UPPER: page = 1'b1;
      MIR_VERT:  page = a[10];
      MIR_HORZ:  page = a[11];
      default:   page = 1'b0;
    endcase
    return {page, a[9:0]};
  endfunction

  function automatic logic [4:0] pal_slot(input logic [13:0] a);
    logic [4:0] i;
    i = a[4:0];
    if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
    return i;
  endfunction

  function automatic logic [7:0] vram_read(input logic [13:0] a);
    if (a < 14'h2000) return pat_mem[a[12:0]];
    if (a < 14'h3F00) return nt_mem[nt_slot(a)];
    return {2'b00, pal_mem[pal_slot(a)]};
  endfunction

  task automatic vram_write(input logic [13:0] a, input logic [7:0] d);
    if (a < 14'h2000) begin
      if (pat_wr) begin
        pat_mem[a[12:0]] = d;
        pat_known[a[12:0]] = 1'b1;
      end
    end else if (a < 14'h3F00) begin
      nt_mem[nt_slot(a)] = d;
    end else begin
      pal_mem[pal_slot(a)] = d[5:0];
    end
  endtask

  task automatic predict_item(input in_item_t it);
    out_item_t   r;
    logic [7:0]  d;
    logic [13:0] a;
    logic [14:0] w;
    logic [4:0]  y;
    int          dots;
    d = it.write_data;
    a = v_addr[13:0];
    r = '0;
    case (it.operation)
      OP_WRITE: begin
        case (it.register_index)
          REG_CTRL: begin
            t_addr[11:10] = d[1:0];
            if (d[7] && !ctrl_q[7] && vblank) r.nmi_request = 1'b1;
            ctrl_q = d;
          end
          REG_MASK: mask_q = d;
          REG_OAMA: oam_addr = d;
          REG_OAMD: begin
            spr_mem[oam_addr] = d;
            oam_addr = oam_addr + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle) begin
              t_addr[4:0] = d[7:3];
              fine_q = d[2:0];
            end else begin
              t_addr[14:12] = d[2:0];
              t_addr[9:5] = d[7:3];
            end
            toggle = !toggle;
          end
          REG_ADDR: begin
            if (!toggle) begin
              t_addr[14] = 1'b0;
              t_addr[13:8] = d[5:0];
            end else begin
              t_addr[7:0] = d;
              v_addr = t_addr;
            end
            toggle = !toggle;
          end
          REG_DATA: begin
            vram_write(a, d);
            v_addr = v_addr + (ctrl_q[2] ? 15'd32 : 15'd1);
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (it.register_index)
          REG_STATUS: begin
            r.read_data = {vblank, 7'd0};
            vblank = 1'b0;
            toggle = 1'b0;
          end
          REG_OAMD: r.read_data = spr_mem[oam_addr];
          REG_DATA: begin
            if (a >= 14'h3F00) begin
              r.read_data = {2'b00, pal_mem[pal_slot(a)]};
              rd_buf = vram_read(a & 14'h2FFF);
            end else begin
              r.read_data = rd_buf;
              rd_buf = vram_read(a);
            end
            v_addr = v_addr + (ctrl_q[2] ? 15'd32 : 15'd1);
          end
          default: ;
        endcase
      end
      OP_ELAPSE: begin
        dots = dot_q + 3 * it.cpu_cycles;
        while (dots >= 341) begin
          dots -= 341;
          if (line_q < 240) begin
            if (mask_q[4:3] != 2'b00) begin
              if (r.mapper_clocks != 2'd3) r.mapper_clocks++;
              w = v_addr;
              if (w[14:12] != 3'b111) begin
                w[14:12] = w[14:12] + 3'd1;
              end else begin
                y = w[9:5];
                w[14:12] = 3'b000;
                if (y == 5'd29) begin
                  y = 5'd0;
                  w[11] = !w[11];
                end else if (y == 5'd31) begin
                  y = 5'd0;
                end else begin
                  y++;
                end
                w[9:5] = y;
              end
              w[10] = t_addr[10];
              w[4:0] = t_addr[4:0];
              v_addr = w;
            end
          end else if (line_q == 261 && mask_q[4:3] != 2'b00) begin
            v_addr = t_addr;
          end
          line_q++;
          if (line_q > 261) begin
            line_q = 0;
            r.frame_done = 1'b1;
          end
          if (line_q == 241) begin
            vblank = 1'b1;
            if (ctrl_q[7]) r.nmi_request = 1'b1;
          end else if (line_q == 261) begin
            vblank = 1'b0;
          end
        end
        dot_q = dots;
      end
      default: ;
    endcase
    r.vram_address = v_addr;
    r.fine_scroll = fine_q;
    r.line_number = line_q[8:0];
    result_q.push_back(r);
  endtask

  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    // keep reads off pattern bytes that were never written
    if (it.operation == OP_READ && it.register_index == REG_DATA &&
        v_addr[13:0] < 14'h2000 && !pat_known[v_addr[12:0]])
      it.register_index = REG_OAMD;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(input logic idx, input logic [1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_MIRROR) mirror = val;
    else pat_wr = val[0];
  endtask

  function automatic in_item_t make_item(input logic [1:0] op, input logic [2:0] idx,
                                         input logic [7:0] d, input logic [7:0] cyc);
    in_item_t it;
    it.operation = op;
    it.register_index = idx;
    it.write_data = d;
    it.cpu_cycles = cyc;
    return it;
  endfunction

  function automatic in_item_t rand_item;
    in_item_t it;
    int k;
    it = in_item_t'($urandom);
    k = $urandom_range(99);
    if (k < 40) begin
      it.operation = OP_WRITE;
      if ($urandom_range(3) != 0) it.register_index = REG_ADDR + 3'($urandom_range(1));
      if (it.register_index == REG_ADDR && $urandom_range(3) != 0)
        it.write_data[7:6] = 2'b00;
    end else if (k < 62) begin
      it.operation = OP_READ;
      if ($urandom_range(1)) it.register_index = REG_DATA;
    end else if (k < 95) begin
      it.operation = OP_ELAPSE;
      if ($urandom_range(1)) it.cpu_cycles[7:6] = 2'b11;
    end else begin
      it.operation = OP_NONE;
    end
    return it;
  endfunction

  task automatic test_directed;
    send_item(make_item(OP_WRITE, REG_CTRL, 8'h03, 8'hFF));
    send_item(make_item(OP_WRITE, REG_MASK, 8'hFF, 8'h00));
    send_item(make_item(OP_WRITE, REG_OAMA, 8'hFF, 8'h00));
    send_item(make_item(OP_WRITE, REG_OAMD, 8'hA5, 8'h00));
    send_item(make_item(OP_READ,  REG_OAMD, 8'h00, 8'h00));
    send_item(make_item(OP_WRITE, REG_SCROLL, 8'hFF, 8'h00));
    send_item(make_item(OP_WRITE, REG_SCROLL, 8'h00, 8'h00));
    send_item(make_item(OP_WRITE, REG_STATUS, 8'hFF, 8'h00));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h3F, 8'h00));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h10, 8'h00));
    send_item(make_item(OP_WRITE, REG_DATA, 8'hFF, 8'h00));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'hFF, 8'h00));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h00, 8'h00));
    send_item(make_item(OP_READ,  REG_DATA, 8'h00, 8'h00));
    send_item(make_item(OP_READ,  REG_DATA, 8'h00, 8'h00));
    for (int i = 0; i < 8; i++)
      if (i != REG_STATUS && i != REG_OAMD && i != REG_DATA)
        send_item(make_item(OP_READ, 3'(i), 8'hFF, 8'hFF));
    send_item(make_item(OP_NONE, REG_DATA, 8'hFF, 8'hFF));
    for (int i = 0; i < 90; i++)
      send_item(make_item(OP_ELAPSE, REG_CTRL, 8'h00, 8'hFF));
    send_item(make_item(OP_ELAPSE, REG_CTRL, 8'h00, 8'h00));
    send_item(make_item(OP_WRITE, REG_CTRL, 8'h80, 8'h00));
    send_item(make_item(OP_READ,  REG_STATUS, 8'h00, 8'h00));
    drain();
  endtask

  task automatic test_pattern_store;
    set_config(CFG_PAT_WR, 2'd1);
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h00, 8'h00));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h00, 8'h00));
    for (int i = 0; i < 6; i++) send_item(make_item(OP_WRITE, REG_DATA, 8'($urandom), 8'h0));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h00, 8'h00));
    send_item(make_item(OP_WRITE, REG_ADDR, 8'h00, 8'h00));
    for (int i = 0; i < 6; i++) send_item(make_item(OP_READ, REG_DATA, 8'h00, 8'h0));
    drain();
  endtask

  task automatic test_random;
    for (int p = 0; p < 8; p++) begin
      set_config(CFG_MIRROR, 2'(p));
      set_config(CFG_PAT_WR, 2'(p / 2 % 2));
      calm = (p == 3);
      for (int i = 0; i < 100; i++) send_item(rand_item());
      drain();
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure;
    calm = 1'b1;
    hold_req++;
    for (int i = 0; i < 40; i++) send_item(rand_item());
    drain();
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected transfer: %h", out_data);
        fails++;
      end else begin
        e = result_q.pop_front();
        check_field("read_data", e.read_data, out_data.read_data);
        check_field("nmi_request", e.nmi_request, out_data.nmi_request);
        check_field("frame_done", e.frame_done, out_data.frame_done);
        check_field("mapper_clocks", e.mapper_clocks, out_data.mapper_clocks);
        check_field("vram_address", e.vram_address, out_data.vram_address);
        check_field("fine_scroll", e.fine_scroll, out_data.fine_scroll);
        check_field("line_number", e.line_number, out_data.line_number);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    mirror = MIR_LOWER; pat_wr = 1'b0;
    ctrl_q = '0; mask_q = '0; oam_addr = '0; rd_buf = '0;
    vblank = 1'b0; toggle = 1'b0; v_addr = '0; t_addr = '0; fine_q = '0;
    line_q = 0; dot_q = 0;
    foreach (nt_mem[i]) nt_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    foreach (spr_mem[i]) spr_mem[i] = '0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pattern_store();
    test_random();
    test_backpressure();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
